// ----- rtl/band_copy_with_union_merge_unit_assert.svh -----
// assertion macros for the band copy and union merge unit
// used by the port checker, needs clk and rst in scope
`ifndef BAND_COPY_WITH_UNION_MERGE_UNIT_ASSERT_SVH
`define BAND_COPY_WITH_UNION_MERGE_UNIT_ASSERT_SVH

// checked only outside reset
`define BCU_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("band unit port check failed");

// checked through reset as well
`define BCU_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("band unit port check failed during reset");

`endif

// ----- rtl/bcu_pkg.sv -----
// shared types and constants of the band copy and union merge unit
// no dependencies
`timescale 1ns / 1ps

package bcu_pkg;

  localparam int COORD_W = 16;
  localparam int COUNT_W = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [COUNT_W-1:0] count_t;

  // one incoming band rectangle with its band context
  typedef struct packed {
    coord_t rect_left;
    coord_t rect_right;
    logic   band_end;
    logic   union_valid;
    coord_t union_left;
    coord_t union_right;
    coord_t new_top;
    coord_t new_bottom;
  } item_t;

  // one emitted rectangle
  typedef struct packed {
    coord_t out_left;
    coord_t out_right;
    coord_t out_top;
    coord_t out_bottom;
    count_t out_count;
    logic   out_last;
  } result_t;

  // up to two results produced by one item, first one is res0
  typedef struct packed {
    logic [1:0] num;
    result_t    res0;
    result_t    res1;
  } result_pair_t;

endpackage

// ----- rtl/bcu_band_logic.sv -----
// per-item band merge decision and band state (phase, merged left, count)
// depends on bcu_pkg
`timescale 1ns / 1ps

module bcu_band_logic #(
  parameter int BAND_ITEMS = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  bcu_pkg::item_t       item,
  output bcu_pkg::result_pair_t pair
);
  import bcu_pkg::*;

  localparam int COUNT_CAP_I = (BAND_ITEMS + 1 > 2047) ? 2047 : BAND_ITEMS + 1;
  localparam logic [COUNT_W:0] COUNT_CAP = (COUNT_W+1)'(COUNT_CAP_I);

  typedef enum logic [1:0] {PH_BEFORE, PH_OVERLAP, PH_AFTER} phase_t;

  phase_t phase, phase_next;
  coord_t merged_left, merged_left_next;
  count_t emitted_count, emitted_count_next;

  coord_t     e0_left, e0_right, e1_left, e1_right;
  logic [1:0] num;
  coord_t     ml;
  logic [COUNT_W:0] c1, c2;

  always_comb begin
    num = 2'd0;
    e0_left = item.rect_left;
    e0_right = item.rect_right;
    e1_left = item.rect_left;
    e1_right = item.rect_right;
    phase_next = phase;
    merged_left_next = merged_left;
    ml = (item.rect_left < item.union_left) ? item.rect_left : item.union_left;
    if (phase != PH_BEFORE) begin
      ml = merged_left;
    end
    case (phase)
      PH_BEFORE, PH_OVERLAP: begin
        if (phase == PH_BEFORE && !item.union_valid) begin
          // no span in this band: plain copy from here on
          num = 2'd1;
          phase_next = PH_AFTER;
        end else if (phase == PH_BEFORE && item.rect_right < item.union_left) begin
          num = 2'd1;
          if (item.band_end) begin
            num = 2'd2;
            e1_left = item.union_left;
            e1_right = item.union_right;
          end
        end else if (item.rect_right >= item.union_right) begin
          phase_next = PH_AFTER;
          merged_left_next = ml;
          if (item.rect_left < item.union_right) begin
            num = 2'd1;
            e0_left = ml;
          end else begin
            // disjoint: merged span then this rectangle
            num = 2'd2;
            e0_left = ml;
            e0_right = item.union_right;
          end
        end else begin
          // absorbed into the span
          phase_next = PH_OVERLAP;
          merged_left_next = ml;
          if (item.band_end) begin
            num = 2'd1;
            e0_left = ml;
            e0_right = item.union_right;
          end
        end
      end
      default: begin
        num = 2'd1;
      end
    endcase
    if (item.band_end) begin
      phase_next = PH_BEFORE;
      merged_left_next = '0;
    end
  end

  // saturating count for each result
  always_comb begin
    c1 = {1'b0, emitted_count};
    if (c1 < COUNT_CAP) begin
      c1 = c1 + 1'b1;
    end
    c2 = c1;
    if (c2 < COUNT_CAP) begin
      c2 = c2 + 1'b1;
    end
    if (item.band_end) begin
      emitted_count_next = '0;
    end else if (num == 2'd2) begin
      emitted_count_next = c2[COUNT_W-1:0];
    end else if (num == 2'd1) begin
      emitted_count_next = c1[COUNT_W-1:0];
    end else begin
      emitted_count_next = emitted_count;
    end
  end

  always_comb begin
    pair.num = num;
    pair.res0.out_left = e0_left;
    pair.res0.out_right = e0_right;
    pair.res0.out_top = item.new_top;
    pair.res0.out_bottom = item.new_bottom;
    pair.res0.out_count = c1[COUNT_W-1:0];
    pair.res0.out_last = item.band_end && (num == 2'd1);
    pair.res1.out_left = e1_left;
    pair.res1.out_right = e1_right;
    pair.res1.out_top = item.new_top;
    pair.res1.out_bottom = item.new_bottom;
    pair.res1.out_count = c2[COUNT_W-1:0];
    pair.res1.out_last = item.band_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_BEFORE;
      merged_left <= '0;
      emitted_count <= '0;
    end else if (take) begin
      phase <= phase_next;
      merged_left <= merged_left_next;
      emitted_count <= emitted_count_next;
    end
  end

endmodule

// ----- rtl/bcu_out_queue.sv -----
// four-entry result queue, takes zero to two results a cycle, gives one while out_ready is high
// depends on bcu_pkg
`timescale 1ns / 1ps

module bcu_out_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  bcu_pkg::result_pair_t pair,
  output logic                  room,
  output logic                  out_valid,
  input  logic                  out_ready,
  output bcu_pkg::result_t      out_res
);
  import bcu_pkg::*;

  result_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic [QCNT_W-1:0]  add;
  logic               pop;

  assign pop = out_valid && out_ready;
  assign add = push ? QCNT_W'(pair.num) : '0;
  // room for a full pair whatever the output side does
  assign room = count <= QCNT_W'(QUEUE_DEPTH - 2);
  assign out_valid = count != '0;
  assign out_res = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && pair.num != 2'd0) begin
      mem[wr_ptr] <= pair.res0;
    end
    if (push && pair.num == 2'd2) begin
      mem[wr_ptr + 1'b1] <= pair.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + add[QPTR_W-1:0];
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + add - QCNT_W'(pop);
    end
  end

endmodule

// ----- rtl/band_copy_with_union_merge_unit.sv -----
// top level of the band copy and union merge unit
// depends on bcu_pkg, bcu_band_logic, bcu_out_queue
//
// channel | dir | tdata (low bit up)                                  | side bits
// s_      | in  | rect_left, rect_right, union_left, union_right,     | tlast band_end,
//         |     | new_top, new_bottom (96 bits)                       | tuser union_valid
// m_      | out | out_left, out_right, out_top, out_bottom, out_count | tlast out_last
//         |     | (75 bits, zero padded to 80)                        |
//
// one rectangle per cycle while the input does not stall; an item waits in the input register, then
//   its results enter the output queue and show on m_ once earlier results have left the queue
// an item that gives two results leaves on m_ as two separate transfers
// input stalls while the input register is full and the four-entry output queue holds more than two results
// rst is synchronous active high and clears band state and queue pointers
`timescale 1ns / 1ps

module band_copy_with_union_merge_unit #(
  parameter int BAND_ITEMS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // rect_left, rect_right, union_left, union_right, new_top, new_bottom
  input  logic        s_tlast,  // band_end
  input  logic        s_tuser,  // union_valid
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,  // out_left, out_right, out_top, out_bottom, out_count, zero pad
  output logic        m_tlast   // out_last
);
  import bcu_pkg::*;

  // input register
  logic         in_valid;
  item_t        in_item;
  logic         room;
  logic         take;
  result_pair_t pair;
  result_t      head;

  // item moves from input register into the queue when a full pair fits
  assign take = in_valid && room;
  // input register frees up when empty or when its item moves on
  assign s_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.rect_left <= s_tdata[15:0];
      in_item.rect_right <= s_tdata[31:16];
      in_item.band_end <= s_tlast;
      in_item.union_valid <= s_tuser;
      in_item.union_left <= s_tdata[47:32];
      in_item.union_right <= s_tdata[63:48];
      in_item.new_top <= s_tdata[79:64];
      in_item.new_bottom <= s_tdata[95:80];
    end
  end

  // merge decision and band state
  bcu_band_logic #(
    .BAND_ITEMS(BAND_ITEMS)
  ) u_band (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (in_item),
    .pair (pair)
  );

  // result buffer, parts input side from output stalls
  bcu_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .pair      (pair),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (head)
  );

  assign m_tdata = {5'b0, head.out_count, head.out_bottom, head.out_top,
                    head.out_right, head.out_left};
  assign m_tlast = head.out_last;

endmodule

// ----- rtl/bcu_port_checker.sv -----
// port checker for the band copy and union merge unit, bound to the top
// depends on band_copy_with_union_merge_unit_assert.svh
`timescale 1ns / 1ps

module bcu_port_checker #(
  parameter int BAND_ITEMS = 1024
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic        m_tlast
);
  `include "band_copy_with_union_merge_unit_assert.svh"

  localparam int CAP_I = (BAND_ITEMS + 1 > 2047) ? 2047 : BAND_ITEMS + 1;
  localparam logic [11:0] CAP = 12'(CAP_I);

  logic [11:0] cnt;
  assign cnt = {1'b0, m_tdata[74:64]};

  // stalled output item holds
  `BCU_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // every shown item counts itself
  `BCU_ASSERT(a_count_nonzero, m_tvalid |-> cnt != 12'd0)

  // back to back items within a band count up by one or stay at the cap
  `BCU_ASSERT(a_count_step, m_tvalid && m_tready && !m_tlast ##1 m_tvalid && m_tready |-> cnt == $past(cnt) + 12'd1 || (cnt == $past(cnt) && cnt == CAP))

  // queue is empty right after reset
  `BCU_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid)

endmodule

bind band_copy_with_union_merge_unit bcu_port_checker #(
  .BAND_ITEMS(BAND_ITEMS)
) u_port_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
